### hdl/dsdc_pkg.sv
// shared types, constants and month tables for the date string to day count block
// no dependencies; imported by every module of the block

package dsdc_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_FORMAT = 3'd1,
    ST_BAD_MONTH  = 3'd2,
    ST_BAD_YEAR   = 3'd3,
    ST_BAD_DAY    = 3'd4
  } status_t;

  // finished date fields handed from the character parser to the calculator
  typedef struct packed {
    logic [7:0]  month;
    logic [7:0]  day;
    logic [13:0] year;
    logic        format_error;
  } date_fields_t;

  // character codes
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // field selector values
  localparam logic [1:0] FIELD_MONTH = 2'd0;
  localparam logic [1:0] FIELD_DAY   = 2'd1;
  localparam logic [1:0] FIELD_YEAR  = 2'd2;

  // accumulator ceilings and year limits
  localparam logic [11:0] MONTH_MAX   = 12'd255;
  localparam logic [11:0] DAY_MAX     = 12'd255;
  localparam logic [17:0] YEAR_MAX    = 18'd16383;
  localparam logic [13:0] YEAR_LIMIT  = 14'd9999;
  localparam logic [13:0] TWO_DIGIT   = 14'd100;
  localparam logic [13:0] CENTURY_19  = 14'd1900;
  localparam logic [13:0] CENTURY_20  = 14'd2000;
  localparam logic [13:0] BASE_RESET  = 14'd1980;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam logic [8:0]  DAYS_YEAR   = 9'd365;

  // reciprocal of 100: floor(x * 5243 / 2^19) == floor(x / 100) for x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // days in each month of a common year, zero for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days of a common year that come before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] days;
    unique case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

### hdl/dsdc_parser.sv
// character parser: decimal field accumulators and field separator tracking
// depends on dsdc_pkg; hands the finished fields of a string to dsdc_calc

module dsdc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  output logic                  fields_valid,
  output dsdc_pkg::date_fields_t fields,
  input  logic                  fields_ready
);
  import dsdc_pkg::*;

  logic [7:0]  month_accum;
  logic [7:0]  day_accum;
  logic [13:0] year_accum;
  logic [1:0]  field_index;
  logic        format_error;

  logic [7:0]  month_accum_next;
  logic [7:0]  day_accum_next;
  logic [13:0] year_accum_next;
  logic [1:0]  field_index_next;
  logic        format_error_next;

  logic        accept;
  logic        is_sep;
  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] month_x10;
  logic [11:0] day_x10;
  logic [17:0] year_x10;

  // hold the input only while a finished string waits for the calculator
  assign in_stall = fields_valid && !fields_ready;
  assign accept   = in_valid && !in_stall;

  // character class
  assign is_sep   = (char_code == CH_DASH) || (char_code == CH_SLASH);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = char_code[3:0];

  // times ten plus digit, as shifts and adds
  assign month_x10 = (12'(month_accum) << 3) + (12'(month_accum) << 1) + 12'(digit);
  assign day_x10   = (12'(day_accum) << 3) + (12'(day_accum) << 1) + 12'(digit);
  assign year_x10  = (18'(year_accum) << 3) + (18'(year_accum) << 1) + 18'(digit);

  // accumulator update for one character
  always_comb begin
    month_accum_next  = month_accum;
    day_accum_next    = day_accum;
    year_accum_next   = year_accum;
    field_index_next  = field_index;
    format_error_next = format_error;
    if (is_sep) begin
      if (field_index >= FIELD_YEAR) begin
        format_error_next = 1'b1;
      end else begin
        field_index_next = field_index + 2'd1;
      end
    end else if (is_digit) begin
      if (field_index == FIELD_MONTH) begin
        month_accum_next = (month_x10 > MONTH_MAX) ? MONTH_MAX[7:0] : month_x10[7:0];
      end else if (field_index == FIELD_DAY) begin
        day_accum_next = (day_x10 > DAY_MAX) ? DAY_MAX[7:0] : day_x10[7:0];
      end else begin
        year_accum_next = (year_x10 > YEAR_MAX) ? YEAR_MAX[13:0] : year_x10[13:0];
      end
    end else begin
      format_error_next = 1'b1;
    end
  end

  // accumulators, cleared after the last character of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      month_accum  <= '0;
      day_accum    <= '0;
      year_accum   <= '0;
      field_index  <= FIELD_MONTH;
      format_error <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        month_accum  <= '0;
        day_accum    <= '0;
        year_accum   <= '0;
        field_index  <= FIELD_MONTH;
        format_error <= 1'b0;
      end else begin
        month_accum  <= month_accum_next;
        day_accum    <= day_accum_next;
        year_accum   <= year_accum_next;
        field_index  <= field_index_next;
        format_error <= format_error_next;
      end
    end
  end

  // finished fields register: a new string refills it, else it empties when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      fields_valid <= 1'b0;
    end else if (accept && last_char) begin
      fields_valid <= 1'b1;
    end else if (fields_ready) begin
      fields_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      fields.month        <= month_accum_next;
      fields.day          <= day_accum_next;
      fields.year         <= year_accum_next;
      fields.format_error <= format_error_next;
    end
  end

endmodule

### hdl/dsdc_calc.sv
// day count calculator: year window, range checks, leap counts and day sum
// depends on dsdc_pkg; takes finished fields from dsdc_parser, drives the result register

module dsdc_calc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fields_valid,
  input  dsdc_pkg::date_fields_t fields,
  output logic                   fields_ready,
  input  logic [13:0]            year_base,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dsdc_pkg::status_t      out_status,
  output logic [21:0]            out_count
);
  import dsdc_pkg::*;

  // stage registers
  logic        v2, v3, v4;
  logic [13:0] s2_year;
  status_t     s2_status;
  logic [3:0]  s2_month;
  logic [7:0]  s2_day;
  logic [13:0] s3_year;
  status_t     s3_status;
  logic [3:0]  s3_month;
  logic [7:0]  s3_day;
  logic [8:0]  s3_c100_y;
  logic [8:0]  s3_c100_b;
  status_t     s4_status;
  logic [9:0]  s4_doy;
  logic [12:0] s4_leap_diff;
  logic [21:0] s4_days365;

  logic        rdy_out, rdy4, rdy3;

  // stage a signals
  logic signed [15:0] window;
  logic               add_2000;
  logic [13:0]        year_a;
  status_t            status_a;

  // stage b signals
  logic [14:0] y99;
  logic [14:0] b99;
  logic [27:0] prod_y;
  logic [27:0] prod_b;

  // stage c signals
  logic [14:0] y_round;
  logic        div4, div100, div400, leap;
  logic [4:0]  feb, limit;
  logic        day_bad;
  status_t     status_c;
  logic [9:0]  doy_c;
  logic [12:0] leap_diff_c;
  logic [13:0] year_diff;
  logic [22:0] days365_c;

  // stage d signals
  logic [21:0] total;

  // number of leap years below y, given c100 = ceil(y / 100)
  function automatic logic [12:0] leaps_below(input logic [13:0] y, input logic [8:0] c100);
    logic [14:0] c4;
    logic [9:0]  c400;
    c4   = (15'(y) + 15'd3) >> 2;
    c400 = (10'(c100) + 10'd3) >> 2;
    return c4[12:0] - 13'(c100) + 13'(c400);
  endfunction

  // stall chain: a stage moves on when the next one is empty or moving
  assign rdy_out      = !out_valid || !out_stall;
  assign rdy4         = !v4 || rdy_out;
  assign rdy3         = !v3 || rdy4;
  assign fields_ready = !v2 || rdy3;

  // stage a: two-digit year window, format, month and year checks
  assign window   = signed'({2'b00, year_base}) - signed'({2'b00, CENTURY_19});
  assign add_2000 = signed'({2'b00, fields.year}) < window;

  always_comb begin
    year_a = fields.year;
    if (fields.year < TWO_DIGIT) begin
      year_a = fields.year + (add_2000 ? CENTURY_20 : CENTURY_19);
    end
  end

  always_comb begin
    priority if (fields.format_error) begin
      status_a = ST_BAD_FORMAT;
    end else if (fields.month == 8'd0 || fields.month > 8'(MONTH_DEC)) begin
      status_a = ST_BAD_MONTH;
    end else if (year_a > YEAR_LIMIT || year_a < year_base) begin
      status_a = ST_BAD_YEAR;
    end else begin
      status_a = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (fields_ready) begin
      v2 <= fields_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fields_ready) begin
      s2_year   <= year_a;
      s2_status <= status_a;
      s2_month  <= fields.month[3:0];
      s2_day    <= fields.day;
    end
  end

  // stage b: ceil(year / 100) by reciprocal multiply, for the year and the base year
  assign y99    = 15'(s2_year) + 15'd99;
  assign b99    = 15'(year_base) + 15'd99;
  assign prod_y = 28'(y99) * 28'(RECIP_100);
  assign prod_b = 28'(b99) * 28'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_year   <= s2_year;
      s3_status <= s2_status;
      s3_month  <= s2_month;
      s3_day    <= s2_day;
      s3_c100_y <= prod_y[RECIP_SHIFT +: 9];
      s3_c100_b <= prod_b[RECIP_SHIFT +: 9];
    end
  end

  // stage c: leap year, day check, day of year, leap difference, whole years
  assign y_round = (15'(s3_c100_y) << 6) + (15'(s3_c100_y) << 5) + (15'(s3_c100_y) << 2);
  assign div4    = (s3_year[1:0] == 2'b00);
  assign div100  = (y_round == 15'(s3_year));
  assign div400  = div100 && (s3_c100_y[1:0] == 2'b00);
  assign leap    = (div4 && !div100) || div400;
  assign feb     = leap ? 5'd29 : 5'd28;
  assign limit   = (s3_month == MONTH_FEB) ? feb : month_len(s3_month);
  assign day_bad = (s3_day == 8'd0) || (s3_day > 8'(limit));

  assign status_c = (s3_status == ST_OK && day_bad) ? ST_BAD_DAY : s3_status;
  assign doy_c    = 10'(s3_day) + 10'(days_before(s3_month))
                  + 10'(leap && s3_month > MONTH_FEB);
  assign leap_diff_c = leaps_below(s3_year, s3_c100_y) - leaps_below(year_base, s3_c100_b);
  assign year_diff   = s3_year - year_base;
  assign days365_c   = 23'(year_diff) * 23'(DAYS_YEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_status    <= status_c;
      s4_doy       <= doy_c;
      s4_leap_diff <= leap_diff_c;
      s4_days365   <= days365_c[21:0];
    end
  end

  // stage d: final sum, zero on any error
  assign total = s4_days365 + 22'(s4_leap_diff) + 22'(s4_doy);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_out) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_status <= s4_status;
      out_count  <= (s4_status == ST_OK) ? total : '0;
    end
  end

endmodule

### hdl/date_string_to_day_count.sv
// top level of the date string to day count block
// depends on dsdc_pkg, dsdc_parser and dsdc_calc

// Reads a month-day-year date string one character per cycle while in_stall is low
// ('-' or '/' between fields); on the character marked last_char, returns a status and
// the day count since January 1 of base_year (that day is 1; the count is 0 on any error).
// A string passes from the parser's fields register through a four-stage pipeline (year
// window and checks, reciprocal divide by 100, leap and day-of-year terms, sum) into the
// result register. The input stalls only when these are all full behind a stalled result.
// base_year resets to 1980 and must be written through the cfg port only while no string
// is in flight; the block itself does not enforce this.

module date_string_to_day_count (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] base_year,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [21:0] day_count
);
  import dsdc_pkg::*;

  logic         year_base;
  logic [13:0]  year_base_reg;
  logic         fields_valid;
  logic         fields_ready;
  date_fields_t fields;
  status_t      result_status;

  // configuration register, always ready
  assign cfg_ready = 1'b1;
  assign year_base = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_base_reg <= BASE_RESET;
    end else if (year_base) begin
      year_base_reg <= base_year;
    end
  end

  // character parser
  dsdc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .fields_valid (fields_valid),
    .fields       (fields),
    .fields_ready (fields_ready)
  );

  // day count pipeline and result register
  dsdc_calc u_calc (
    .clk          (clk),
    .rst          (rst),
    .fields_valid (fields_valid),
    .fields       (fields),
    .fields_ready (fields_ready),
    .year_base    (year_base_reg),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (result_status),
    .out_count    (day_count)
  );

  assign status = result_status;

  // an error result carries no day count
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_status != ST_OK) |-> (day_count == 22'd0))
    else $error("error result with nonzero day count");

  // a good date counts at least its own day
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_status == ST_OK) |-> (day_count != 22'd0))
    else $error("good result with zero day count");

  // the input stalls only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result side can move");

endmodule
